// ----- design/apa_pkg.sv -----
// ----------------------------------------------------------------------------
// apa_pkg
// types and constants of the cascaded pid attitude autopilot
// ----------------------------------------------------------------------------
package apa_pkg;

  localparam int NUM_LOOPS    = 4;
  localparam int LOOP_IDX_W   = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int DIV_W        = 52;
  localparam int DEN_W        = 20;
  localparam int DIV_CNT_W    = 6;

  localparam logic [DEN_W-1:0]  DT_SCALE        = 20'd1000000;
  localparam logic signed [16:0] HALF_TURN      = 17'sd11520;
  localparam logic signed [16:0] FULL_TURN      = 17'sd23040;
  localparam logic [13:0]       MAX_BEARING_RST = 14'd1920;
  localparam logic [6:0]        THROTTLE_MAX    = 7'd100;

  // 2^60 / 10^6 rounded up, split at bit 20
  localparam logic [19:0]       RECIP_LO        = 20'd658271;
  localparam logic [20:0]       RECIP_HI        = 21'd1099511;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEVATOR      = 3'd0,
    REG_HEADING       = 3'd1,
    REG_ROLL          = 3'd2,
    REG_RUDDER        = 3'd3,
    REG_MAX_BEARING   = 3'd4,
    REG_DESIRED_PITCH = 3'd5
  } cfg_reg_e;

  typedef enum logic [LOOP_IDX_W-1:0] {
    LOOP_ELEVATOR = 2'd0,
    LOOP_HEADING  = 2'd1,
    LOOP_ROLL     = 2'd2,
    LOOP_RUDDER   = 2'd3
  } loop_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_ERR,
    ST_MUL1,
    ST_RLO,
    ST_RHI,
    ST_INT,
    ST_MUL2,
    ST_MUL3,
    ST_ISUM,
    ST_DIV2,
    ST_SUM,
    ST_OUT
  } state_e;

endpackage

// ----- design/apa_if.sv -----
// ----------------------------------------------------------------------------
// apa_if
// input, result and configuration channels of the autopilot core
// ----------------------------------------------------------------------------
interface apa_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch;
  logic        [14:0] heading;
  logic signed [14:0] roll;
  logic signed [15:0] lateral_accel;
  logic        [15:0] dt_us;
  modport source (output valid, pitch, heading, roll, lateral_accel, dt_us, input ready);
  modport sink   (input valid, pitch, heading, roll, lateral_accel, dt_us, output ready);
endinterface

interface apa_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] elevator_cmd;
  logic signed [15:0] aileron_cmd;
  logic signed [15:0] rudder_cmd;
  logic        [6:0]  throttle_pct;
  modport source (output valid, elevator_cmd, aileron_cmd, rudder_cmd, throttle_pct,
                  input ready);
  modport sink   (input valid, elevator_cmd, aileron_cmd, rudder_cmd, throttle_pct,
                  output ready);
endinterface

interface apa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/attitude_pid_autopilot_step_core.sv -----
// the core takes no new word until the previous result is loaded; each of the four loops
//   runs a 52-step restoring division by dt; a full output register stalls
// reset: integrals and last errors read as zero, heading unlatched, throttle 0
// ----------------------------------------------------------------------------
// attitude_pid_autopilot_step_core
// cascaded pid autopilot; loop state kept in a small synchronous memory
// ----------------------------------------------------------------------------
module attitude_pid_autopilot_step_core
  import apa_pkg::*;
#(
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  apa_in_if.sink      in_s,
  apa_out_if.source   out_s,
  apa_cfg_if.sink     cfg_s
);

  localparam int IW  = INTEGRAL_WIDTH;
  localparam int LW  = IW / 2;
  localparam int HW  = IW - LW;
  localparam int AW  = ((IW > 28) ? IW : 28) + 1;
  localparam int SW  = ((IW > DIV_W + 1) ? IW : DIV_W + 1) + 2;
  localparam int MW  = IW + 16;
  localparam int KW  = IW + 17;

  localparam logic signed [AW:0] IMAX = $signed({{(AW + 2 - IW){1'b0}}, {(IW - 1){1'b1}}});
  localparam logic signed [AW:0] IMIN = -IMAX - 1;

  function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
    logic signed [15:0] r;
    if (v > $signed(SW'(32767))) begin
      r = 16'sh7fff;
    end else if (v < $signed(-SW'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] loop_cfg_q [NUM_LOOPS];
  logic [13:0]           maxb_q;
  logic signed [14:0]    dpitch_q;

  logic signed [14:0] pitch_q, roll_q;
  logic        [14:0] head_q, dh_q;
  logic signed [15:0] acc_q;
  logic        [15:0] dt_q;
  logic               latched_q;
  logic        [6:0]  thr_q;
  logic [LOOP_IDX_W-1:0] k_q;

  logic [MW-1:0]    mem_q [NUM_LOOPS];
  logic [MW-1:0]    rdata_q;
  logic [NUM_LOOPS-1:0] vld_q;

  logic signed [IW-1:0]    integ_q, int_new_q;
  logic signed [15:0]      e_q, last_q;
  logic signed [16:0]      de_q;
  logic signed [32:0]      prod_q, kdde_q;
  logic signed [31:0]      p_q;
  logic signed [LW+16:0]   kilo_q;
  logic signed [HW+15:0]   kihi_q;
  logic signed [53:0]      big_q;
  logic signed [IW:0]      iterm_q;
  logic signed [SW-1:0]    h_q;
  logic signed [15:0]      elev_q, ail_q, rud_q;
  logic [51:0]             rlo_q;

  logic [DIV_W-1:0]     dq_q;
  logic [DEN_W-1:0]     rem_q, den_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  logic               ov_q;
  logic signed [15:0] o_elev_q, o_ail_q, o_rud_q;
  logic        [6:0]  o_thr_q;

  logic signed [15:0] kp, ki, kd, sp;
  logic signed [16:0] a0, a1, a2, maxs;
  logic signed [SW-1:0] e_raw;
  logic [DEN_W:0]       rem_sh;
  logic                 ge;
  logic [31:0]          prod_mag;
  logic [52:0]          rsum;
  logic [53:0]          big_mag;
  logic signed [AW-1:0] inc;
  logic signed [AW:0]   isum;
  logic signed [KW-1:0] kii, kii_adj;
  logic signed [DIV_W:0] dterm;
  logic signed [SW-1:0] s_sum, s_h, s_r;
  logic in_acc, out_load;

  assign kp = loop_cfg_q[k_q][15:0];
  assign ki = loop_cfg_q[k_q][31:16];
  assign kd = loop_cfg_q[k_q][47:32];
  assign sp = loop_cfg_q[k_q][63:48];

  assign cfg_s.ready = 1'b1;
  assign in_s.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_s.valid && in_s.ready;
  assign out_load    = (state_q == ST_OUT) && (!ov_q || out_s.ready);

  assign out_s.valid        = ov_q;
  assign out_s.elevator_cmd = o_elev_q;
  assign out_s.aileron_cmd  = o_ail_q;
  assign out_s.rudder_cmd   = o_rud_q;
  assign out_s.throttle_pct = o_thr_q;

  // bearing error with a single wrap and clamp
  always_comb begin
    a0   = $signed({2'b00, dh_q}) - $signed({2'b00, head_q});
    maxs = $signed({3'b000, maxb_q});
    if (a0 > HALF_TURN) begin
      a1 = a0 - FULL_TURN;
    end else if (a0 < -HALF_TURN) begin
      a1 = a0 + FULL_TURN;
    end else begin
      a1 = a0;
    end
    if (a1 > maxs) begin
      a2 = maxs;
    end else if (a1 < -maxs) begin
      a2 = -maxs;
    end else begin
      a2 = a1;
    end
  end

  always_comb begin
    unique case (loop_e'(k_q))
      LOOP_ELEVATOR: e_raw = SW'(sp) - (SW'(dpitch_q) - SW'(pitch_q));
      LOOP_HEADING:  e_raw = SW'(sp) - SW'(a2);
      LOOP_ROLL:     e_raw = h_q + SW'(roll_q);
      LOOP_RUDDER:   e_raw = SW'(sp) - SW'(acc_q);
      default:       e_raw = '0;
    endcase
  end

  always_comb begin
    rem_sh   = {rem_q, dq_q[DIV_W-1]};
    ge       = rem_sh >= {1'b0, den_q};
    prod_mag = prod_q[32] ? 32'(-prod_q) : 32'(prod_q);
    rsum     = {21'd0, prod_mag} * {32'd0, RECIP_HI} + {21'd0, rlo_q[51:20]};
    big_mag  = big_q[53] ? 54'(-big_q) : 54'(big_q);
    inc      = neg_q ? -$signed({1'b0, dq_q[AW-2:0]}) : $signed({1'b0, dq_q[AW-2:0]});
    isum     = (AW + 1)'(integ_q) + (AW + 1)'(inc);
    kii      = (KW'(kihi_q) <<< LW) + KW'(kilo_q);
    kii_adj  = kii + ((kii < 0) ? KW'(65535) : KW'(0));
    dterm    = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
    s_sum    = SW'(p_q) + SW'(iterm_q) + SW'(dterm);
    s_h      = (s_sum + ((s_sum < 0) ? SW'(255) : SW'(0))) >>> 8;
    s_r      = (s_sum + ((s_sum < 0) ? SW'(3) : SW'(0))) >>> 2;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RD;
      ST_RD:   state_d = ST_ERR;
      ST_ERR:  state_d = ST_MUL1;
      ST_MUL1: state_d = ST_RLO;
      ST_RLO:  state_d = ST_RHI;
      ST_RHI:  state_d = ST_INT;
      ST_INT:  state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_ISUM;
      ST_ISUM: state_d = ST_DIV2;
      ST_DIV2: if (cnt_q == '0) state_d = ST_SUM;
      ST_SUM:  state_d = (loop_e'(k_q) == LOOP_RUDDER) ? ST_OUT : ST_RD;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      for (int i = 0; i < NUM_LOOPS; i++) loop_cfg_q[i] <= '0;
      maxb_q    <= MAX_BEARING_RST;
      dpitch_q  <= '0;
      latched_q <= 1'b0;
      dh_q      <= '0;
      thr_q     <= '0;
      vld_q     <= '0;
      ov_q      <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_s.valid) begin
        unique case (cfg_reg_e'(cfg_s.index))
          REG_ELEVATOR:      loop_cfg_q[LOOP_ELEVATOR] <= cfg_s.data;
          REG_HEADING:       loop_cfg_q[LOOP_HEADING]  <= cfg_s.data;
          REG_ROLL:          loop_cfg_q[LOOP_ROLL]     <= cfg_s.data;
          REG_RUDDER:        loop_cfg_q[LOOP_RUDDER]   <= cfg_s.data;
          REG_MAX_BEARING:   maxb_q   <= cfg_s.data[13:0];
          REG_DESIRED_PITCH: dpitch_q <= cfg_s.data[14:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        k_q <= '0;
        if (thr_q < THROTTLE_MAX) thr_q <= thr_q + 7'd1;
        if (!latched_q) begin
          dh_q      <= in_s.heading;
          latched_q <= 1'b1;
        end
      end
      if (state_q == ST_SUM) begin
        vld_q[k_q] <= 1'b1;
        k_q        <= k_q + 1'b1;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_s.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // loop state memory
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) rdata_q <= mem_q[k_q];
    if (state_q == ST_SUM) mem_q[k_q] <= {int_new_q, e_q};
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pitch_q <= in_s.pitch;
      head_q  <= in_s.heading;
      roll_q  <= in_s.roll;
      acc_q   <= in_s.lateral_accel;
      dt_q    <= (in_s.dt_us == '0) ? 16'd1 : in_s.dt_us;
    end
    if (out_load) begin
      o_elev_q <= elev_q;
      o_ail_q  <= ail_q;
      o_rud_q  <= rud_q;
      o_thr_q  <= thr_q;
    end
    unique case (state_q)
      ST_ERR: begin
        integ_q <= vld_q[k_q] ? rdata_q[MW-1:16] : '0;
        last_q  <= vld_q[k_q] ? rdata_q[15:0] : '0;
        e_q     <= sat16(e_raw);
      end
      ST_MUL1: begin
        prod_q <= e_q * $signed({1'b0, dt_q});
        p_q    <= kp * e_q;
      end
      // |e * dt| * 1024 / 15625 by reciprocal multiplication over the ST_RLO and ST_RHI states
      ST_RLO: begin
        rlo_q <= {20'd0, prod_mag} * {32'd0, RECIP_LO};
        neg_q <= prod_q[32];
      end
      ST_RHI: begin
        dq_q <= DIV_W'(rsum[52:24]);
      end
      ST_DIV2: begin
        dq_q  <= {dq_q[DIV_W-2:0], ge};
        rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
        cnt_q <= cnt_q - 1'b1;
      end
      ST_INT: begin
        if (isum > IMAX) begin
          int_new_q <= IMAX[IW-1:0];
        end else if (isum < IMIN) begin
          int_new_q <= IMIN[IW-1:0];
        end else begin
          int_new_q <= isum[IW-1:0];
        end
        de_q <= 17'(e_q) - 17'(last_q);
      end
      ST_MUL2: begin
        kilo_q <= ki * $signed({1'b0, int_new_q[LW-1:0]});
        kdde_q <= kd * de_q;
      end
      ST_MUL3: begin
        kihi_q <= ki * $signed(int_new_q[IW-1:LW]);
        big_q  <= kdde_q * $signed({1'b0, DT_SCALE});
      end
      ST_ISUM: begin
        iterm_q <= (IW + 1)'(kii_adj >>> 16);
        dq_q    <= DIV_W'(big_mag);
        den_q   <= DEN_W'(dt_q);
        neg_q   <= big_q[53];
        rem_q   <= '0;
        cnt_q   <= DIV_CNT_W'(DIV_W - 1);
      end
      ST_SUM: begin
        unique case (loop_e'(k_q))
          LOOP_ELEVATOR: elev_q <= sat16(-s_sum);
          LOOP_HEADING:  h_q    <= s_h;
          LOOP_ROLL:     ail_q  <= sat16(-s_sum);
          LOOP_RUDDER:   rud_q  <= sat16(-s_r);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_s.ready)
    else $error("input taken again while busy");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == ST_OUT))
    else $error("result word raised outside output state");

  a_throttle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_q <= THROTTLE_MAX)
    else $error("throttle level above limit");
`endif

endmodule
